### rtl/core/bsfe_pkg.sv
// shared types, constants and codes for the byte stuffing frame encoder
`default_nettype none

package bsfe_pkg;

   // default configuration
   localparam int PREAMBLE_LEN_DEF = 8;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // line codes
   localparam logic [7:0] SYNC_BYTE = 8'hA5;
   localparam logic [7:0] ESC_HI    = 8'hA6;
   localparam logic [7:0] END_BYTE  = 8'h5A;
   localparam logic [7:0] ESC_LO    = 8'h5B;
   localparam logic [7:0] ESC_SELF  = 8'h01;
   localparam logic [7:0] ESC_MARK  = 8'h02;

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_last;
   } req_payload_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_payload_type;

   // classified item handed from front to back
   typedef struct packed {
      logic       preamble;
      logic       escape;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       last;
   } cmd_type;

   // back end sequencer steps
   typedef enum logic [2:0] {
      PH_NEW,
      PH_PRE,
      PH_FIRST,
      PH_SECOND,
      PH_END
   } phase_type;

endpackage

`default_nettype wire

### rtl/core/bsfe_front.sv
// front end: accepts input items, tracks frame state and classifies escapes
`default_nettype none

module bsfe_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire bsfe_pkg::req_payload_type req_data,
   input  wire logic                     queue_full,
   output logic                          queue_push,
   output bsfe_pkg::cmd_type             queue_cmd
);
   import bsfe_pkg::*;

   logic in_frame_ff;
   logic in_frame_in;

   // accept handshake
   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

   // escape decode
   always_comb begin
      queue_cmd.preamble    = !in_frame_ff;
      queue_cmd.last        = req_data.frame_last;
      queue_cmd.escape      = 1'b1;
      queue_cmd.first_byte  = req_data.data_byte;
      queue_cmd.second_byte = ESC_MARK;
      unique case (req_data.data_byte)
         SYNC_BYTE: begin
            queue_cmd.first_byte  = ESC_HI;
            queue_cmd.second_byte = ESC_MARK;
         end
         ESC_HI: begin
            queue_cmd.first_byte  = ESC_HI;
            queue_cmd.second_byte = ESC_SELF;
         end
         END_BYTE: begin
            queue_cmd.first_byte  = ESC_LO;
            queue_cmd.second_byte = ESC_MARK;
         end
         ESC_LO: begin
            queue_cmd.first_byte  = ESC_LO;
            queue_cmd.second_byte = ESC_SELF;
         end
         default: begin
            queue_cmd.escape = 1'b0;
         end
      endcase
   end

   // frame state: set by an accepted item that does not close its frame, cleared by one that does
   always_comb begin
      in_frame_in = in_frame_ff;
      if (queue_push) begin
         in_frame_in = !req_data.frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/bsfe_queue.sv
// short queue of classified items between front and back end
`default_nettype none

module bsfe_queue #(
   parameter int QUEUE_DEPTH = bsfe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bsfe_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output bsfe_pkg::cmd_type     head_cmd
);
   import bsfe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/core/bsfe_back.sv
// back end: steps through preamble, data and escape bytes and end marker into the output register
`default_nettype none

module bsfe_back #(
   parameter int PREAMBLE_LEN = bsfe_pkg::PREAMBLE_LEN_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire bsfe_pkg::cmd_type    head_cmd,
   output logic                      head_pop,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output bsfe_pkg::rsp_payload_type rsp_data
);
   import bsfe_pkg::*;

   localparam int PRE_W = (PREAMBLE_LEN > 1) ? $clog2(PREAMBLE_LEN) : 1;

   phase_type        phase_ff, phase_in, cur_phase;
   logic [PRE_W-1:0] pre_cnt_ff, pre_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             out_free, step, done;

   // one result byte per cycle while an item waits and the output register frees up
   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign step      = head_valid && out_free;
   assign head_pop  = step && done;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // step sequencer
   always_comb begin
      cur_phase = phase_ff;
      if (phase_ff == PH_NEW) begin
         cur_phase = head_cmd.preamble ? PH_PRE : PH_FIRST;
      end
      phase_in              = phase_ff;
      pre_cnt_in            = pre_cnt_ff;
      done                  = 1'b0;
      rsp_data_in.out_byte  = SYNC_BYTE;
      rsp_data_in.run_last  = 1'b0;
      rsp_data_in.frame_end = 1'b0;
      unique case (cur_phase)
         PH_PRE: begin
            rsp_data_in.out_byte = SYNC_BYTE;
            if (pre_cnt_ff == PRE_W'(PREAMBLE_LEN - 1)) begin
               pre_cnt_in = '0;
               phase_in   = PH_FIRST;
            end else begin
               pre_cnt_in = pre_cnt_ff + 1'b1;
               phase_in   = PH_PRE;
            end
         end
         PH_FIRST: begin
            rsp_data_in.out_byte = head_cmd.first_byte;
            if (head_cmd.escape) begin
               phase_in = PH_SECOND;
            end else if (head_cmd.last) begin
               phase_in = PH_END;
            end else begin
               done                 = 1'b1;
               rsp_data_in.run_last = 1'b1;
               phase_in             = PH_NEW;
            end
         end
         PH_SECOND: begin
            rsp_data_in.out_byte = head_cmd.second_byte;
            if (head_cmd.last) begin
               phase_in = PH_END;
            end else begin
               done                 = 1'b1;
               rsp_data_in.run_last = 1'b1;
               phase_in             = PH_NEW;
            end
         end
         PH_END: begin
            rsp_data_in.out_byte  = END_BYTE;
            rsp_data_in.run_last  = 1'b1;
            rsp_data_in.frame_end = 1'b1;
            done                  = 1'b1;
            phase_in              = PH_NEW;
         end
         default: begin
            phase_in = PH_NEW;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NEW;
         pre_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff   <= phase_in;
            pre_cnt_ff <= pre_cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/byte_stuffing_frame_encoder.sv
// top level of the byte stuffing frame encoder
// an accepted item is written into the queue; its first result byte is then registered in the output register
// one result byte per cycle while the output register is free; an item gives 1 or 2 bytes, plus PREAMBLE_LEN
//   sync bytes when it opens a frame and an end byte when it closes one
// input side takes a new item every cycle until the QUEUE_DEPTH entry queue fills
// synchronous reset empties queue and output register and returns to between frames
`default_nettype none

module byte_stuffing_frame_encoder #(
   parameter int PREAMBLE_LEN = bsfe_pkg::PREAMBLE_LEN_DEF,
   parameter int QUEUE_DEPTH  = bsfe_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire bsfe_pkg::req_payload_type req_data,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output bsfe_pkg::rsp_payload_type      rsp_data
);
   import bsfe_pkg::*;

   logic    queue_full, queue_push, head_valid, head_pop;
   cmd_type queue_cmd, head_cmd;

   // accept and classify
   bsfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_cmd  (queue_cmd)
   );

   // decoupling queue
   bsfe_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (queue_cmd),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // byte sequencer and output register
   bsfe_back #(
      .PREAMBLE_LEN (PREAMBLE_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/core/bsfe_checker.sv
// port level checks for the byte stuffing frame encoder and their bind
`default_nettype none

module bsfe_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_push,
   input wire logic                      req_full,
   input wire bsfe_pkg::req_payload_type req_data,
   input wire logic                      rsp_empty,
   input wire logic                      rsp_pop,
   input wire bsfe_pkg::rsp_payload_type rsp_data
);
   import bsfe_pkg::*;

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // end marker is always the last result of its item
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_end) |->
         (rsp_data.out_byte == END_BYTE && rsp_data.run_last))
      else $error("end marker flags wrong");

   // escape lead bytes are never the final result of an item
   a_escape_lead: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.out_byte == ESC_HI || rsp_data.out_byte == ESC_LO))
         |-> !rsp_data.run_last)
      else $error("escape lead byte closes an item");

   // reset leaves no result and room for input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("state not cleared by reset");

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### verif/tb_byte_stuffing_frame_encoder.sv
// testbench for the byte stuffing frame encoder: random frames, escape prediction, line checks
`timescale 1ns / 1ps

module tb_byte_stuffing_frame_encoder;
   import bsfe_pkg::*;

   localparam int PREAMBLE_LEN = PREAMBLE_LEN_DEF;
   localparam int RAND_ITEMS   = 350;
   localparam int IDLE_PCT     = 12;
   // receiver hold-off window and the stretch with no idling, in cycles
   localparam int HOLD_AT      = 600;
   localparam int HOLD_LEN     = 100;
   localparam int CALM_FROM    = 150;
   localparam int CALM_TO      = 450;
   localparam int DRAIN_CYCLES = 30;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_push  = 1'b0;
   logic            req_full;
   req_payload_type req_data  = '0;
   logic            rsp_empty;
   logic            rsp_pop   = 1'b0;
   rsp_payload_type rsp_data;

   req_payload_type frame_bytes_q[$];
   rsp_payload_type line_bytes_q[$];
   bit              frame_open = 1'b0;
   int              mismatch_cnt = 0;
   int              cyc_cnt = 0;
   int              hold_cnt = 0;

   byte_stuffing_frame_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cyc_cnt <= cyc_cnt + 1;
   end

   // no random idling on either side inside this window
   wire calm = (cyc_cnt >= CALM_FROM) && (cyc_cnt < CALM_TO);

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_cnt++;
   endtask

   // append one line byte to the expected stream
   function automatic void push_line(input logic [7:0] b, input logic fin);
      rsp_payload_type r;
      r.out_byte  = b;
      r.run_last  = 1'b0;
      r.frame_end = fin;
      line_bytes_q = {line_bytes_q, r};
   endfunction

   // expected line bytes for one accepted frame byte
   function automatic void encode_frame_byte(input req_payload_type item);
      rsp_payload_type r;
      if (!frame_open) begin
         for (int i = 0; i < PREAMBLE_LEN; i++) push_line(SYNC_BYTE, 1'b0);
         frame_open = 1'b1;
      end
      case (item.data_byte)
         SYNC_BYTE: begin
            push_line(ESC_HI, 1'b0);
            push_line(ESC_MARK, 1'b0);
         end
         ESC_HI: begin
            push_line(ESC_HI, 1'b0);
            push_line(ESC_SELF, 1'b0);
         end
         END_BYTE: begin
            push_line(ESC_LO, 1'b0);
            push_line(ESC_MARK, 1'b0);
         end
         ESC_LO: begin
            push_line(ESC_LO, 1'b0);
            push_line(ESC_SELF, 1'b0);
         end
         default: push_line(item.data_byte, 1'b0);
      endcase
      if (item.frame_last) begin
         push_line(END_BYTE, 1'b1);
         frame_open = 1'b0;
      end
      // flag the final line byte of this item
      r = line_bytes_q.pop_back();
      r.run_last = 1'b1;
      line_bytes_q = {line_bytes_q, r};
   endfunction

   task automatic add_item(input logic [7:0] b, input logic fin);
      req_payload_type item;
      item.data_byte  = b;
      item.frame_last = fin;
      frame_bytes_q = {frame_bytes_q, item};
   endtask

   // random byte biased toward the escaped codes and their neighbors
   function automatic logic [7:0] pick_byte();
      logic [7:0] codes [8];
      codes = '{SYNC_BYTE, ESC_HI, END_BYTE, ESC_LO, 8'hA4, 8'hA7, 8'h59, 8'h5C};
      if ($urandom_range(99) < 30) return codes[$urandom_range(7)];
      return 8'($urandom_range(255));
   endfunction

   // driver: present queued frame bytes, hold an item until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            encode_frame_byte(req_data);
            frame_bytes_q.delete(0);
         end
         if (req_push && req_full) begin
            req_push <= 1'b1;
         end else if (frame_bytes_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_push <= 1'b1;
            req_data <= frame_bytes_q[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // long receiver hold-off counter so the block backs up and asserts full
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (cyc_cnt == HOLD_AT) begin
         hold_cnt <= HOLD_LEN;
      end
   end

   // monitor: check each popped line byte against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (line_bytes_q.size() == 0) begin
               report_mismatch($sformatf("unexpected line byte %02h", rsp_data.out_byte));
            end else begin
               want = line_bytes_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                     rsp_data.out_byte, want.out_byte));
               if (rsp_data.run_last !== want.run_last)
                  report_mismatch($sformatf("run_last %b, want %b on byte %02h",
                     rsp_data.run_last, want.run_last, want.out_byte));
               if (rsp_data.frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, want %b on byte %02h",
                     rsp_data.frame_end, want.frame_end, want.out_byte));
            end
         end
         // stall the result side during the hold-off
         if (hold_cnt > 0 || cyc_cnt == HOLD_AT) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // stimulus and end of run
   initial begin
      int n;
      int len;
      // single-byte frames: each escaped code, the escape suffix codes and field extremes
      add_item(SYNC_BYTE, 1'b1);
      add_item(ESC_HI, 1'b1);
      add_item(END_BYTE, 1'b1);
      add_item(ESC_LO, 1'b1);
      add_item(8'h00, 1'b1);
      add_item(8'hFF, 1'b1);
      add_item(ESC_SELF, 1'b1);
      add_item(ESC_MARK, 1'b1);
      // multi-byte frame through all codes and their neighbors
      add_item(8'h00, 1'b0);
      add_item(SYNC_BYTE, 1'b0);
      add_item(8'hA4, 1'b0);
      add_item(ESC_HI, 1'b0);
      add_item(8'hA7, 1'b0);
      add_item(END_BYTE, 1'b0);
      add_item(8'h59, 1'b0);
      add_item(ESC_LO, 1'b0);
      add_item(8'h5C, 1'b0);
      add_item(8'hFF, 1'b1);
      // back-to-back escapes closing a frame
      add_item(SYNC_BYTE, 1'b0);
      add_item(SYNC_BYTE, 1'b0);
      add_item(END_BYTE, 1'b1);
      // random frames, mostly short
      n = 0;
      while (n < RAND_ITEMS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         for (int i = 0; i < len; i++) add_item(pick_byte(), i == len - 1);
         n += len;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (frame_bytes_q.size() > 0) @(posedge clock);
      while (line_bytes_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

endmodule
